@@ hdl/tpag_pkg.sv @@
// ----------------------------------------------------------------------------
// tpag_pkg
// Shared types and constants of the tensor permute address generator.
// ----------------------------------------------------------------------------
package tpag_pkg;

   localparam int MAX_AXES     = 4;
   localparam int AXIS_W       = $clog2(MAX_AXES);
   localparam int DIM_WIDTH    = 16;
   localparam int SHAPE_SLOT_W = 16;
   localparam int ADDR_WIDTH   = 32;
   localparam int STRIDE_SLOT_W = 32;
   localparam int COUNT_W      = 3;
   localparam int ORDER_W      = 8;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_INDEX_W  = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_AXIS_COUNT       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_AXIS_ORDER       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_OUT_SHAPE        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SRC_STRIDE_LOW   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SRC_STRIDE_HIGH  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_DST_STRIDE_LOW   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_DST_STRIDE_HIGH  = 3'd6;

   localparam logic [COUNT_W-1:0]    AXIS_COUNT_RESET = 3'd4;
   localparam logic [ORDER_W-1:0]    AXIS_ORDER_RESET = 8'hE4;
   localparam logic [CSR_DATA_W-1:0] OUT_SHAPE_RESET  = 64'h0001_0001_0001_0001;

   typedef logic [ADDR_WIDTH-1:0] addr_type;
   typedef logic [DIM_WIDTH-1:0]  dim_type;

   typedef struct packed {
      logic [COUNT_W-1:0]                  axis_count;
      logic [ORDER_W-1:0]                  axis_order;
      logic [CSR_DATA_W-1:0]               out_shape;
      logic [MAX_AXES-1:0][ADDR_WIDTH-1:0] src_stride;
      logic [MAX_AXES-1:0][ADDR_WIDTH-1:0] dst_stride;
   } cfg_type;

   typedef struct packed {
      addr_type src_index;
      addr_type dst_index;
      logic     last_element;
   } result_type;

endpackage

@@ hdl/tpag_odometer.sv @@
// ----------------------------------------------------------------------------
// tpag_odometer
// Per-axis coordinate odometer with running source and destination partial
// offsets; gives the address pair of the current position and advances on
// each step.
// ----------------------------------------------------------------------------
module tpag_odometer
   import tpag_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step,
   input  logic       restart,
   output result_type result
);

   dim_type  [MAX_AXES-1:0] coord_ff, coord_in;
   addr_type [MAX_AXES-1:0] src_part_ff, src_part_in;
   addr_type [MAX_AXES-1:0] dst_part_ff, dst_part_in;

   dim_type  [MAX_AXES-1:0] coord_eff;
   addr_type [MAX_AXES-1:0] src_eff;
   addr_type [MAX_AXES-1:0] dst_eff;
   logic                    last_carry;

   always_comb begin
      for (int ax = 0; ax < MAX_AXES; ax++) begin
         coord_eff[ax] = restart ? '0 : coord_ff[ax];
         src_eff[ax]   = restart ? '0 : src_part_ff[ax];
         dst_eff[ax]   = restart ? '0 : dst_part_ff[ax];
      end
   end

   always_comb begin
      addr_type src_sum;
      addr_type dst_sum;
      src_sum = '0;
      dst_sum = '0;
      for (int ax = 0; ax < MAX_AXES; ax++) begin
         src_sum = src_sum + src_eff[ax];
         dst_sum = dst_sum + dst_eff[ax];
      end
      result.src_index    = src_sum;
      result.dst_index    = dst_sum;
      result.last_element = last_carry;
   end

   always_comb begin
      logic                 carry;
      logic [DIM_WIDTH:0]   next_coord;
      dim_type              dim_raw;
      logic                 dim_one;
      logic [AXIS_W-1:0]    src_axis;
      carry      = 1'b1;
      next_coord = '0;
      dim_raw    = '0;
      dim_one    = 1'b0;
      src_axis   = '0;
      coord_in    = coord_eff;
      src_part_in = src_eff;
      dst_part_in = dst_eff;
      for (int ax = MAX_AXES - 1; ax >= 0; ax--) begin
         dim_raw    = cfg.out_shape[SHAPE_SLOT_W*ax +: DIM_WIDTH];
         dim_one    = (COUNT_W'(ax) >= cfg.axis_count) || (dim_raw == '0);
         next_coord = {1'b0, coord_eff[ax]} + (DIM_WIDTH+1)'(1);
         src_axis   = cfg.axis_order[AXIS_W*ax +: AXIS_W];
         if (carry) begin
            if (dim_one || (next_coord >= {1'b0, dim_raw})) begin
               coord_in[ax]    = '0;
               src_part_in[ax] = '0;
               dst_part_in[ax] = '0;
            end else begin
               coord_in[ax]    = next_coord[DIM_WIDTH-1:0];
               src_part_in[ax] = src_eff[ax] + cfg.src_stride[src_axis];
               dst_part_in[ax] = dst_eff[ax] + cfg.dst_stride[ax];
               carry           = 1'b0;
            end
         end
      end
      last_carry = carry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coord_ff    <= '0;
         src_part_ff <= '0;
         dst_part_ff <= '0;
      end else if (step) begin
         coord_ff    <= coord_in;
         src_part_ff <= src_part_in;
         dst_part_ff <= dst_part_in;
      end
   end

   a_restart_zero: assert property (@(posedge clock) disable iff (reset)
      step && restart |-> result.src_index == '0 && result.dst_index == '0)
      else $error("restart step did not start at offset zero");

   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      step && result.last_element |=> coord_ff == '0)
      else $error("coordinates not cleared after last element");

   a_not_last_moves: assert property (@(posedge clock) disable iff (reset)
      step && !result.last_element |=> coord_ff != '0)
      else $error("odometer failed to advance");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(coord_ff) && $stable(src_part_ff))
      else $error("odometer moved without a step");

endmodule

@@ hdl/tensor_permute_address_generator.sv @@
// ----------------------------------------------------------------------------
// tensor_permute_address_generator
// Source/destination element offset generator for permuting a tensor of up
// to four axes.
// ----------------------------------------------------------------------------
// One request beat yields one response beat carrying the (src, dst) offset
// pair of the current output position and a flag on the tensor's final
// element; the odometer then steps, innermost axis fastest, and wraps after
// the last element. Throughput is one beat per cycle while the skid register
// is empty: the four-way partial sum and the stride adds are combinational, and a
// two-entry output queue (result register and skid register) holds the offset
// pairs and takes one further request while a response is stalled. Write
// configuration only while no beats are outstanding.
module tensor_permute_address_generator
   import tpag_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_restart,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output addr_type               rsp_src_index,
   output addr_type               rsp_dst_index,
   output logic                   rsp_last_element
);

   logic [COUNT_W-1:0]    axis_count_ff;
   logic [ORDER_W-1:0]    axis_order_ff;
   logic [CSR_DATA_W-1:0] out_shape_ff;
   logic [CSR_DATA_W-1:0] src_stride_low_ff, src_stride_high_ff;
   logic [CSR_DATA_W-1:0] dst_stride_low_ff, dst_stride_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_count_ff      <= AXIS_COUNT_RESET;
         axis_order_ff      <= AXIS_ORDER_RESET;
         out_shape_ff       <= OUT_SHAPE_RESET;
         src_stride_low_ff  <= '0;
         src_stride_high_ff <= '0;
         dst_stride_low_ff  <= '0;
         dst_stride_high_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_AXIS_COUNT:      axis_count_ff      <= csr_wr_data[COUNT_W-1:0];
            REG_AXIS_ORDER:      axis_order_ff      <= csr_wr_data[ORDER_W-1:0];
            REG_OUT_SHAPE:       out_shape_ff       <= csr_wr_data;
            REG_SRC_STRIDE_LOW:  src_stride_low_ff  <= csr_wr_data;
            REG_SRC_STRIDE_HIGH: src_stride_high_ff <= csr_wr_data;
            REG_DST_STRIDE_LOW:  dst_stride_low_ff  <= csr_wr_data;
            REG_DST_STRIDE_HIGH: dst_stride_high_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   cfg_type cfg;

   always_comb begin
      cfg.axis_count    = axis_count_ff;
      cfg.axis_order    = axis_order_ff;
      cfg.out_shape     = out_shape_ff;
      cfg.src_stride[0] = src_stride_low_ff[ADDR_WIDTH-1:0];
      cfg.src_stride[1] = src_stride_low_ff[STRIDE_SLOT_W +: ADDR_WIDTH];
      cfg.src_stride[2] = src_stride_high_ff[ADDR_WIDTH-1:0];
      cfg.src_stride[3] = src_stride_high_ff[STRIDE_SLOT_W +: ADDR_WIDTH];
      cfg.dst_stride[0] = dst_stride_low_ff[ADDR_WIDTH-1:0];
      cfg.dst_stride[1] = dst_stride_low_ff[STRIDE_SLOT_W +: ADDR_WIDTH];
      cfg.dst_stride[2] = dst_stride_high_ff[ADDR_WIDTH-1:0];
      cfg.dst_stride[3] = dst_stride_high_ff[STRIDE_SLOT_W +: ADDR_WIDTH];
   end

   logic       push, pop;
   result_type result;

   tpag_odometer u_odometer (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step    (push),
      .restart (req_restart),
      .result  (result)
   );

   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;

   assign req_ready = !skid_valid_ff;
   assign push      = req_valid && req_ready;
   assign pop       = out_valid_ff && rsp_ready;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_in       = result;
            skid_valid_in = push;
         end else begin
            out_in        = result;
            out_valid_in  = push;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_src_index    = out_ff.src_index;
   assign rsp_dst_index    = out_ff.dst_index;
   assign rsp_last_element = out_ff.last_element;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty result register");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      push |=> out_valid_ff)
      else $error("accepted beat not queued for response");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_ff))
      else $error("stalled response beat changed");

endmodule

@@ tb/permute_address_checker.sv @@
// ----------------------------------------------------------------------------
// permute_address_checker
// Tracks register writes and request beats to predict the source/destination
// offset pair of every response beat and compares it with what the generator
// returns, in order. Reports a running mismatch count and the number of
// responses still owed.
// ----------------------------------------------------------------------------
module permute_address_checker
   import tpag_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic                   req_restart,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  addr_type               rsp_src_index,
   input  addr_type               rsp_dst_index,
   input  logic                   rsp_last_element,
   output int                     mismatch_count,
   output int                     outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [COUNT_W-1:0]    axis_count_q;
   logic [ORDER_W-1:0]    axis_order_q;
   logic [CSR_DATA_W-1:0] out_shape_q;
   addr_type              src_stride_q [MAX_AXES];
   addr_type              dst_stride_q [MAX_AXES];
   dim_type               coord_q      [MAX_AXES];
   addr_type              src_part_q   [MAX_AXES];
   addr_type              dst_part_q   [MAX_AXES];
   result_type            expected_pairs [$];
   int                    errors = 0;

   function automatic void clear_odometer();
      for (int ax = 0; ax < MAX_AXES; ax++) begin
         coord_q[ax]    = '0;
         src_part_q[ax] = '0;
         dst_part_q[ax] = '0;
      end
   endfunction

   function automatic result_type next_offset_pair(input logic restart);
      result_type          pair;
      logic                carry;
      logic [DIM_WIDTH:0]  next;
      logic [DIM_WIDTH:0]  dim;
      logic [AXIS_W-1:0]   src_axis;
      pair  = '0;
      carry = 1'b1;
      if (restart) clear_odometer();
      for (int ax = 0; ax < MAX_AXES; ax++) begin
         pair.src_index += src_part_q[ax];
         pair.dst_index += dst_part_q[ax];
      end
      // advance the odometer, innermost axis first
      for (int ax = MAX_AXES - 1; ax >= 0 && carry; ax--) begin
         dim = {1'b0, out_shape_q[SHAPE_SLOT_W*ax +: DIM_WIDTH]};
         if (ax >= axis_count_q || dim == 0) dim = 1;
         next = {1'b0, coord_q[ax]} + 1'b1;
         if (next >= dim) begin
            coord_q[ax]    = '0;
            src_part_q[ax] = '0;
            dst_part_q[ax] = '0;
         end else begin
            src_axis       = axis_order_q[AXIS_W*ax +: AXIS_W];
            coord_q[ax]    = next[DIM_WIDTH-1:0];
            src_part_q[ax] = src_part_q[ax] + src_stride_q[src_axis];
            dst_part_q[ax] = dst_part_q[ax] + dst_stride_q[ax];
            carry          = 1'b0;
         end
      end
      pair.last_element = carry;
      return pair;
   endfunction

   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         axis_count_q = AXIS_COUNT_RESET;
         axis_order_q = AXIS_ORDER_RESET;
         out_shape_q  = OUT_SHAPE_RESET;
         for (int ax = 0; ax < MAX_AXES; ax++) begin
            src_stride_q[ax] = '0;
            dst_stride_q[ax] = '0;
         end
         clear_odometer();
         expected_pairs.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_AXIS_COUNT: axis_count_q = csr_wr_data[COUNT_W-1:0];
               REG_AXIS_ORDER: axis_order_q = csr_wr_data[ORDER_W-1:0];
               REG_OUT_SHAPE:  out_shape_q  = csr_wr_data;
               REG_SRC_STRIDE_LOW: begin
                  src_stride_q[0] = csr_wr_data[0 +: STRIDE_SLOT_W];
                  src_stride_q[1] = csr_wr_data[STRIDE_SLOT_W +: STRIDE_SLOT_W];
               end
               REG_SRC_STRIDE_HIGH: begin
                  src_stride_q[2] = csr_wr_data[0 +: STRIDE_SLOT_W];
                  src_stride_q[3] = csr_wr_data[STRIDE_SLOT_W +: STRIDE_SLOT_W];
               end
               REG_DST_STRIDE_LOW: begin
                  dst_stride_q[0] = csr_wr_data[0 +: STRIDE_SLOT_W];
                  dst_stride_q[1] = csr_wr_data[STRIDE_SLOT_W +: STRIDE_SLOT_W];
               end
               REG_DST_STRIDE_HIGH: begin
                  dst_stride_q[2] = csr_wr_data[0 +: STRIDE_SLOT_W];
                  dst_stride_q[3] = csr_wr_data[STRIDE_SLOT_W +: STRIDE_SLOT_W];
               end
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_pairs.insert(expected_pairs.size(), next_offset_pair(req_restart));
         if (rsp_valid && rsp_ready) begin
            got.src_index    = rsp_src_index;
            got.dst_index    = rsp_dst_index;
            got.last_element = rsp_last_element;
            if (expected_pairs.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: response beat with nothing pending: src %h dst %h last %b",
                           $realtime, got.src_index, got.dst_index, got.last_element);
            end else begin
               want = expected_pairs.pop_front();
               if (got.src_index !== want.src_index || got.dst_index !== want.dst_index ||
                   got.last_element !== want.last_element) begin
                  errors++;
                  if (errors <= 10)
                     $display({"%0t: mismatch src exp %h got %h, dst exp %h got %h, ",
                               "last exp %b got %b"},
                              $realtime, want.src_index, got.src_index, want.dst_index,
                              got.dst_index, want.last_element, got.last_element);
               end
            end
         end
      end
      mismatch_count <= errors;
      outstanding    <= expected_pairs.size();
   end

endmodule

@@ tb/tb_tensor_permute_address_generator.sv @@
// ----------------------------------------------------------------------------
// tb_tensor_permute_address_generator
// Stimulus and verdict for the tensor permute address generator.
// ----------------------------------------------------------------------------
// Programs a sequence of tensor shapes, axis orders and strides while the
// generator is idle, starting with hand-picked corner settings (zero axes,
// too many axes, zero and full-width dimensions, wrapping strides, changes
// mid-tensor) and then random ones, and streams restart/step beats with
// random gaps and response stalls. The checker predicts every offset pair.
// ----------------------------------------------------------------------------
module tb_tensor_permute_address_generator
   import tpag_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET    = 1400;
   localparam int CALM_ITEMS     = 150;
   localparam int DRAIN_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT = 1000;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;
   logic                   req_valid   = 1'b0;
   logic                   req_restart = 1'b0;
   logic                   rsp_ready   = 1'b0;
   logic                   req_ready;
   logic                   rsp_valid;
   addr_type               rsp_src_index;
   addr_type               rsp_dst_index;
   logic                   rsp_last_element;
   int                     mismatch_count;
   int                     outstanding;
   logic                   calm        = 1'b0;
   int                     stall_left  = 0;
   int                     quiet_cycles = 0;
   int                     sent        = 0;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   tensor_permute_address_generator DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_src_index    (rsp_src_index),
      .rsp_dst_index    (rsp_dst_index),
      .rsp_last_element (rsp_last_element)
   );

   permute_address_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_src_index    (rsp_src_index),
      .rsp_dst_index    (rsp_dst_index),
      .rsp_last_element (rsp_last_element),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   // stall the response side in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready  <= ($urandom_range(0, 2) != 0);
         stall_left <= $urandom_range(1, 15);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   task automatic load_setting(input cfg_type s);
      write_reg(REG_AXIS_COUNT,      CSR_DATA_W'(s.axis_count));
      write_reg(REG_AXIS_ORDER,      CSR_DATA_W'(s.axis_order));
      write_reg(REG_OUT_SHAPE,       s.out_shape);
      write_reg(REG_SRC_STRIDE_LOW,  {s.src_stride[1], s.src_stride[0]});
      write_reg(REG_SRC_STRIDE_HIGH, {s.src_stride[3], s.src_stride[2]});
      write_reg(REG_DST_STRIDE_LOW,  {s.dst_stride[1], s.dst_stride[0]});
      write_reg(REG_DST_STRIDE_HIGH, {s.dst_stride[3], s.dst_stride[2]});
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_beat(input logic restart);
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic addr_type random_stride();
      case ($urandom_range(0, 5))
         0:       return '1;
         1:       return addr_type'($urandom_range(0, 16));
         default: return addr_type'($urandom);
      endcase
   endfunction

   initial begin
      cfg_type                 setting;
      logic [SHAPE_SLOT_W-1:0] slot;
      int                      burst;
      logic                    gapless;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset setting: every dimension one, zero strides
      send_beat(1'b0);
      send_beat(1'b1);

      // 2x3 transpose
      drain_responses();
      setting               = '0;
      setting.axis_count    = 3'd2;
      setting.axis_order    = 8'hE1;
      setting.out_shape     = 64'h0000_0000_0003_0002;
      setting.src_stride[0] = 32'd2;
      setting.src_stride[1] = 32'd1;
      setting.dst_stride[0] = 32'd3;
      setting.dst_stride[1] = 32'd1;
      load_setting(setting);
      send_beat(1'b1);
      repeat (6) send_beat(1'b0);

      // no axes in use
      drain_responses();
      setting.axis_count    = 3'd0;
      setting.axis_order    = 8'h1B;
      setting.out_shape     = 64'h0005_0004_0003_0002;
      setting.src_stride    = {32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'h4444_4444};
      setting.dst_stride    = {32'h0000_0010, 32'h0000_0020, 32'h0000_0030, 32'h0000_0040};
      load_setting(setting);
      send_beat(1'b0);
      send_beat(1'b0);

      // count above four, zero and full-width dimensions, wrapping strides
      drain_responses();
      setting.axis_count    = 3'd7;
      setting.axis_order    = 8'h00;
      setting.out_shape     = 64'hFFFF_0000_0001_0002;
      setting.src_stride    = '1;
      setting.dst_stride    = {4{32'h8000_0001}};
      load_setting(setting);
      send_beat(1'b1);
      repeat (3) send_beat(1'b0);
      send_beat(1'b1);
      send_beat(1'b0);

      // order naming an unused axis, changed mid-tensor
      drain_responses();
      setting.axis_count    = 3'd1;
      setting.axis_order    = 8'hFF;
      setting.out_shape     = 64'h0000_0000_0000_0003;
      setting.src_stride    = {32'hFFFF_FFF0, 32'd5, 32'd5, 32'd5};
      setting.dst_stride    = {32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF};
      load_setting(setting);
      repeat (5) send_beat(1'b0);

      while (sent < ITEM_TARGET) begin
         drain_responses();
         calm <= (sent >= ITEM_TARGET - CALM_ITEMS);
         setting.axis_count = ($urandom_range(0, 7) != 0) ? COUNT_W'($urandom_range(1, 4))
                                                          : COUNT_W'($urandom_range(0, 7));
         setting.axis_order = ORDER_W'($urandom);
         for (int ax = 0; ax < MAX_AXES; ax++) begin
            case ($urandom_range(0, 11))
               0:       slot = SHAPE_SLOT_W'($urandom);
               1:       slot = '1;
               default: slot = SHAPE_SLOT_W'($urandom_range(0, 4));
            endcase
            setting.out_shape[SHAPE_SLOT_W*ax +: SHAPE_SLOT_W] = slot;
            setting.src_stride[ax] = random_stride();
            setting.dst_stride[ax] = random_stride();
         end
         load_setting(setting);
         burst   = $urandom_range(8, 80);
         gapless = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < burst; k++) begin
            send_beat((k == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 29) == 0);
            if (!calm && !gapless && $urandom_range(0, 4) == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 15)) @(posedge clock);
            end
         end
      end

      drain_responses();
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
